// ----- rtl/ssdc_pkg.sv -----
// shared types and constants for the divisible-subarray counter
// no dependencies; used by ssdc_dp, ssdc_ctrl and the top module
package ssdc_pkg;

  localparam int VAL_W       = 16;
  localparam int MOD_W       = 11;
  localparam int TOTAL_W     = 32;
  localparam int CNT_W       = 17;
  localparam int MAX_MODULUS = 1024;
  localparam int RES_W       = $clog2(MAX_MODULUS);
  localparam int SUM_W       = VAL_W + 2;
  localparam int MAG_W       = VAL_W;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = MAG_W / DIV_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int EPOCH_W     = 8;
  localparam int RAM_W       = EPOCH_W + CNT_W;

  localparam logic [CNT_W-1:0]   COUNT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_CLR  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_INIT = EPOCH_W'(1);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_beat_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               last_res;
  } out_beat_t;

  // one histogram entry, valid only when its tag matches the current epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CNT_W-1:0]   count;
  } hist_word_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic look;
    logic update;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic wrap;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_UPD
  } state_e;

endpackage

// ----- rtl/ssdc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module ssdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ssdc_dp.sv -----
// datapath: prefix residue, iterative remainder unit, histogram ram, total
// depends on ssdc_pkg and ssdc_ram
module ssdc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssdc_pkg::dp_cmd_t       cmd_i,
  output ssdc_pkg::dp_stat_t      stat_o,
  input  ssdc_pkg::in_beat_t      in_data_i,
  input  logic                    cfg_we_i,
  input  logic [ssdc_pkg::MOD_W-1:0] cfg_wdata_i,
  output ssdc_pkg::out_beat_t     out_data_o
);

  logic [ssdc_pkg::MOD_W-1:0]   mod_q;
  logic [ssdc_pkg::MOD_W-1:0]   k_q, k_d;
  logic [ssdc_pkg::MAG_W-1:0]   dvd_q, dvd_d;
  logic                         neg_q;
  logic [ssdc_pkg::MOD_W-1:0]   rem_q, rem_d;
  logic [ssdc_pkg::STEP_W-1:0]  step_q;
  logic                         last_q;
  logic [ssdc_pkg::RES_W-1:0]   prefix_q;
  logic [ssdc_pkg::RES_W-1:0]   res_q, res_d;
  logic [ssdc_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [ssdc_pkg::EPOCH_W-1:0] epoch_q;
  logic [ssdc_pkg::RES_W-1:0]   clr_addr_q;
  ssdc_pkg::out_beat_t          out_q;

  logic [ssdc_pkg::SUM_W-1:0]   sum;
  logic [ssdc_pkg::SUM_W-1:0]   sum_mag;
  logic [ssdc_pkg::MOD_W:0]     diff;
  logic [ssdc_pkg::CNT_W-1:0]   old_cnt, upd_cnt;
  logic [ssdc_pkg::TOTAL_W:0]   total_sum;

  ssdc_pkg::hist_word_t ram_wdata, ram_rdata;
  logic [ssdc_pkg::RES_W-1:0] ram_waddr;
  logic                       ram_we;

  // clamp the divisor into 1..MAX_MODULUS
  always_comb begin
    if (mod_q == '0) begin
      k_d = ssdc_pkg::MOD_W'(1);
    end else if (mod_q > ssdc_pkg::MOD_W'(ssdc_pkg::MAX_MODULUS)) begin
      k_d = ssdc_pkg::MOD_W'(ssdc_pkg::MAX_MODULUS);
    end else begin
      k_d = mod_q;
    end
  end

  // prefix + element, then magnitude for the remainder unit
  assign sum = {{(ssdc_pkg::SUM_W-ssdc_pkg::RES_W){1'b0}}, prefix_q}
             + {{(ssdc_pkg::SUM_W-ssdc_pkg::VAL_W){in_data_i.value[ssdc_pkg::VAL_W-1]}},
                in_data_i.value};
  assign sum_mag = sum[ssdc_pkg::SUM_W-1] ? (~sum + ssdc_pkg::SUM_W'(1)) : sum;

  // restoring remainder, DIV_BITS dividend bits per cycle
  always_comb begin
    logic [ssdc_pkg::MOD_W-1:0] r;
    logic [ssdc_pkg::MAG_W-1:0] d;
    logic [ssdc_pkg::MOD_W:0]   t;
    r = rem_q;
    d = dvd_q;
    for (int i = 0; i < ssdc_pkg::DIV_BITS; i++) begin
      t = {r, d[ssdc_pkg::MAG_W-1]};
      if (t >= {1'b0, k_q}) begin
        t = t - {1'b0, k_q};
      end
      r = t[ssdc_pkg::MOD_W-1:0];
      d = {d[ssdc_pkg::MAG_W-2:0], 1'b0};
    end
    rem_d = r;
    dvd_d = d;
  end

  // negative dividend: fold remainder back into 0..k-1
  assign diff = {1'b0, k_q} - {1'b0, rem_q};
  always_comb begin
    if (neg_q && rem_q != '0) begin
      res_d = diff[ssdc_pkg::RES_W-1:0];
    end else begin
      res_d = rem_q[ssdc_pkg::RES_W-1:0];
    end
  end

  // histogram lookup result, a stale epoch tag means never seen in this array
  always_comb begin
    if (ram_rdata.epoch == epoch_q) begin
      old_cnt = ram_rdata.count;
    end else begin
      old_cnt = (res_q == '0) ? ssdc_pkg::CNT_W'(1) : '0;
    end
    upd_cnt = (old_cnt == ssdc_pkg::COUNT_MAX) ? ssdc_pkg::COUNT_MAX
                                                : old_cnt + ssdc_pkg::CNT_W'(1);
    total_sum = {1'b0, total_q} + (ssdc_pkg::TOTAL_W+1)'(old_cnt);
    total_d = total_sum[ssdc_pkg::TOTAL_W] ? ssdc_pkg::TOTAL_MAX
                                           : total_sum[ssdc_pkg::TOTAL_W-1:0];
  end

  always_comb begin
    ram_we = cmd_i.update | cmd_i.clr_step;
    if (cmd_i.clr_step) begin
      ram_waddr       = clr_addr_q;
      ram_wdata.epoch = ssdc_pkg::EPOCH_CLR;
      ram_wdata.count = '0;
    end else begin
      ram_waddr       = res_q;
      ram_wdata.epoch = epoch_q;
      ram_wdata.count = upd_cnt;
    end
  end

  ssdc_ram #(
    .WIDTH(ssdc_pkg::RAM_W),
    .DEPTH(ssdc_pkg::MAX_MODULUS)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.look),
    .raddr_i(res_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q      <= ssdc_pkg::MOD_W'(1);
      step_q     <= '0;
      prefix_q   <= '0;
      total_q    <= '0;
      epoch_q    <= ssdc_pkg::EPOCH_INIT;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + ssdc_pkg::STEP_W'(1);
      end
      if (cmd_i.look) begin
        prefix_q <= res_d;
      end
      if (cmd_i.update) begin
        if (last_q) begin
          prefix_q <= '0;
          total_q  <= '0;
          epoch_q  <= (epoch_q == ssdc_pkg::EPOCH_MAX) ? ssdc_pkg::EPOCH_INIT
                                                       : epoch_q + ssdc_pkg::EPOCH_W'(1);
        end else begin
          total_q <= total_d;
        end
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + ssdc_pkg::RES_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q    <= k_d;
      neg_q  <= sum[ssdc_pkg::SUM_W-1];
      dvd_q  <= sum_mag[ssdc_pkg::MAG_W-1:0];
      rem_q  <= '0;
      last_q <= in_data_i.last;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
    if (cmd_i.look) begin
      res_q <= res_d;
    end
    if (cmd_i.update) begin
      out_q.total    <= total_d;
      out_q.last_res <= last_q;
    end
  end

  assign stat_o.div_last = (step_q == ssdc_pkg::STEP_W'(ssdc_pkg::DIV_STEPS-1));
  assign stat_o.clr_last = (clr_addr_q == ssdc_pkg::RES_W'(ssdc_pkg::MAX_MODULUS-1));
  assign stat_o.wrap     = last_q && (epoch_q == ssdc_pkg::EPOCH_MAX);
  assign out_data_o      = out_q;

endmodule

// ----- rtl/ssdc_ctrl.sv -----
// controller: sequences clear pass, remainder steps, lookup and update
// depends on ssdc_pkg
module ssdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssdc_pkg::dp_cmd_t  cmd_o,
  input  ssdc_pkg::dp_stat_t stat_i
);

  ssdc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ssdc_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ssdc_pkg::ST_IDLE;
      end
      ssdc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ssdc_pkg::ST_DIV;
      end
      ssdc_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = ssdc_pkg::ST_LOOK;
      end
      ssdc_pkg::ST_LOOK: begin
        state_d = ssdc_pkg::ST_UPD;
      end
      ssdc_pkg::ST_UPD: begin
        if (out_free) begin
          state_d = stat_i.wrap ? ssdc_pkg::ST_CLEAR : ssdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssdc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ssdc_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      ssdc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ssdc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ssdc_pkg::ST_LOOK: begin
        cmd_o.look = 1'b1;
      end
      ssdc_pkg::ST_UPD: begin
        cmd_o.update = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssdc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // result register must never be overwritten while a beat waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  a_update_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_q)
    else $error("update did not raise output valid");

  a_div_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssdc_pkg::ST_DIV && stat_i.div_last) |=> cmd_o.look)
    else $error("lookup did not follow last remainder step");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ssdc_pkg::ST_DIV && !cmd_o.load))
    else $error("item taken while busy");

endmodule

// ----- rtl/subarray_sum_divisible_counter.sv -----
// Counts subarrays whose sum is divisible by a configurable modulus.
// Input channel: in_valid_i / in_stall_o with in_data_i (value, last), one
// array element per beat. Output channel: out_valid_o / out_stall_i with
// out_data_o (total, last_res), exactly one result beat per input beat.
// A beat moves at a rising edge where valid is high and stall is low.
// The modulus is written through cfg_we_i / cfg_wdata_i while idle; zero
// acts as 1 and values above 1024 act as 1024.
// Each taken beat passes through four remainder steps of 4 bits each, one
// histogram read and one update before its result shows in out_data_o.
// A new element is taken only after the previous one has passed the remainder
// unit and the read-modify-write on the single histogram ram.
// The output register holds a waiting result while the next element is
// taken; a stalled receiver holds the block only at the update cycle.
// Reset: a clearing pass writes all 1024 histogram ram entries, with
// in_stall_o high throughout; the same pass runs after every 255th array.
// A beat with last set closes the array and clears total and prefix.
// depends on ssdc_pkg, ssdc_ctrl, ssdc_dp
module subarray_sum_divisible_counter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ssdc_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ssdc_pkg::out_beat_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [ssdc_pkg::MOD_W-1:0] cfg_wdata_i
);

  ssdc_pkg::dp_cmd_t  cmd;
  ssdc_pkg::dp_stat_t stat;

  ssdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  ssdc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_data_o (out_data_o)
  );

endmodule
